// ===== sv/ree_pkg.sv =====
// ----------------------------------------------------------------------------
// ree_pkg: shared definitions of the RISC execute stage
// Opcodes, the decoded instruction word and default sizes.
// ----------------------------------------------------------------------------
package ree_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int MEM_WORDS_DEF = 2048;

    localparam int IDX_W = 5;
    localparam int OP_W  = 4;

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MULI = 4'd2;
    localparam logic [OP_W-1:0] OP_ADDI = 4'd3;
    localparam logic [OP_W-1:0] OP_BNE  = 4'd4;
    localparam logic [OP_W-1:0] OP_ANDI = 4'd5;
    localparam logic [OP_W-1:0] OP_ORI  = 4'd6;
    localparam logic [OP_W-1:0] OP_JMP  = 4'd7;
    localparam logic [OP_W-1:0] OP_SLL  = 4'd8;
    localparam logic [OP_W-1:0] OP_SRL  = 4'd9;
    localparam logic [OP_W-1:0] OP_LW   = 4'd10;
    localparam logic [OP_W-1:0] OP_SW   = 4'd11;

    localparam logic [31:0] PC_KEEP_MASK = 32'hF000_0000;
    localparam logic [31:0] RESULT_NONE  = 32'hFFFF_FFFF;

    // Decoded instruction as it waits in the queue.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             bad;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] bsel;
        logic [4:0]       shamt;
        logic [31:0]      imm;
        logic [27:0]      target;
    } item_t;

endpackage

// ===== sv/ree_front.sv =====
// ----------------------------------------------------------------------------
// ree_front: instruction intake
// Accepts words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ree_front import ree_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        clear_done,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    logic [IDX_W-1:0] reg_map [32];
    item_t            dec;
    item_t            q_mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;

    // Register index folding, worked out at elaboration.
    for (genvar g = 0; g < 32; g++) begin : g_map
        assign reg_map[g] = IDX_W'(g % REG_COUNT);
    end

    // Decode of the incoming word.
    always_comb begin
        dec.op     = s_tdata[3:0];
        dec.bad    = (s_tdata[3:0] > OP_SW);
        dec.dest   = reg_map[s_tdata[8:4]];
        dec.src    = reg_map[s_tdata[13:9]];
        dec.bsel   = (s_tdata[3:0] == OP_ADD || s_tdata[3:0] == OP_SUB) ?
                     reg_map[s_tdata[18:14]] : reg_map[s_tdata[8:4]];
        dec.shamt  = s_tdata[23:19];
        dec.imm    = {{14{s_tdata[41]}}, s_tdata[41:24]};
        dec.target = s_tdata[69:42];
    end

    assign s_tready = clear_done && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== sv/ree_back.sv =====
// ----------------------------------------------------------------------------
// ree_back: instruction execution
// Register file, data memory, program counter and the result register.
// ----------------------------------------------------------------------------
module ree_back import ree_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        clear_done,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int AW = $clog2(MEM_WORDS);
    localparam bit MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
    // Reciprocal of the memory depth, scaled so that it fits in 32 bits.
    localparam int          MOD_K     = 32 + AW - 1;
    localparam logic [31:0] MOD_RECIP = 32'((64'd1 << MOD_K) / 64'(MEM_WORDS));

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_MEMA  = 3'd4;
    localparam logic [2:0] S_LOADW = 3'd5;
    localparam logic [2:0] S_MULW  = 3'd6;

    logic [2:0]           state_reg, state_next;
    item_t                cur_reg, cur_next;
    logic [31:0]          pc_reg, pc_next;
    logic [63:0]          prod_reg, prod_next;
    logic [31:0]          sum_reg, sum_next;
    logic [AW-1:0]        mod_reg, mod_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          res_reg, res_next;
    logic                 ovf_reg, ovf_next;
    logic                 bad_reg, bad_next;
    logic [31:0]          pco_reg, pco_next;

    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [31:0]          ra_reg, rb_reg;
    logic                 va_reg, vb_reg;
    logic                 rf_we;
    logic [31:0]          rf_wdata;

    logic [31:0]          dm_mem [MEM_WORDS];
    logic [31:0]          dm_rdata_reg;
    logic                 dm_we;
    logic [AW-1:0]        dm_addr;
    logic [31:0]          dm_wdata;

    logic                 out_free;
    logic                 emit;
    logic [31:0]          a_val, b_val, sum_ab, dif_ab, sum_ai;
    logic [31:0]          mod_quo;

    assign out_free   = !m_valid_reg || m_tready;
    assign q_pop      = (state_reg == S_IDLE) && q_valid && out_free;
    assign clear_done = (state_reg != S_CLEAR);
    assign a_val      = va_reg ? ra_reg : 32'd0;
    assign b_val      = vb_reg ? rb_reg : 32'd0;
    assign sum_ab     = a_val + b_val;
    assign dif_ab     = a_val - b_val;
    assign sum_ai     = a_val + cur_reg.imm;
    assign mod_quo    = 32'(prod_reg >> MOD_K);

    // Sequencer and datapath next values.
    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        pc_next      = pc_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        mod_next     = mod_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        res_next     = res_reg;
        ovf_next     = 1'b0;
        bad_next     = 1'b0;
        emit         = 1'b0;
        rf_we        = 1'b0;
        rf_wdata     = 32'd0;
        dm_we        = 1'b0;
        dm_addr      = mod_reg;
        dm_wdata     = b_val;
        case (state_reg)
            S_CLEAR: begin
                dm_we    = 1'b1;
                dm_addr  = clr_reg;
                dm_wdata = 32'd0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_pop) begin
                    cur_next   = q_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                case (cur_reg.op)
                    OP_ADD: begin
                        res_next = sum_ab;
                        ovf_next = (a_val[31] ^ sum_ab[31]) & (b_val[31] ^ sum_ab[31]);
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_SUB: begin
                        res_next = dif_ab;
                        ovf_next = (a_val[31] ^ b_val[31]) & (a_val[31] ^ dif_ab[31]);
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_MULI: begin
                        prod_next  = $signed(a_val) * $signed(cur_reg.imm);
                        state_next = S_MULW;
                    end
                    OP_ADDI: begin
                        res_next = sum_ai;
                        ovf_next = (a_val[31] ^ sum_ai[31]) & (cur_reg.imm[31] ^ sum_ai[31]);
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_BNE: begin
                        if (a_val != b_val) begin
                            pc_next = pc_reg + 32'd1 + cur_reg.imm;
                        end
                        res_next = RESULT_NONE;
                        emit     = 1'b1;
                    end
                    OP_ANDI: begin
                        res_next = a_val & cur_reg.imm;
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_ORI: begin
                        res_next = a_val | cur_reg.imm;
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_JMP: begin
                        pc_next  = (pc_reg & PC_KEEP_MASK) | {4'd0, cur_reg.target};
                        res_next = RESULT_NONE;
                        emit     = 1'b1;
                    end
                    OP_SLL: begin
                        res_next = a_val << cur_reg.shamt;
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_SRL: begin
                        res_next = a_val >> cur_reg.shamt;
                        rf_we    = 1'b1;
                        emit     = 1'b1;
                    end
                    OP_LW, OP_SW: begin
                        if (MEM_POW2) begin
                            mod_next   = sum_ai[AW-1:0];
                            state_next = S_MEMA;
                        end else begin
                            sum_next   = sum_ai;
                            mod_next   = '0;
                            cnt_next   = 2'd0;
                            state_next = S_MOD;
                        end
                    end
                    default: begin
                        res_next = 32'd0;
                        bad_next = 1'b1;
                        emit     = 1'b1;
                    end
                endcase
                rf_wdata = res_next;
            end
            S_MOD: begin
                // Estimate the quotient by the reciprocal, subtract its multiple,
                // then correct the remainder once.
                case (cnt_reg)
                    2'd0: begin
                        prod_next = sum_reg * MOD_RECIP;
                    end
                    2'd1: begin
                        sum_next = sum_reg - 32'(mod_quo * 32'(MEM_WORDS));
                    end
                    default: begin
                        if (sum_reg >= 32'(MEM_WORDS)) begin
                            mod_next = AW'(sum_reg - 32'(MEM_WORDS));
                        end else begin
                            mod_next = sum_reg[AW-1:0];
                        end
                        state_next = S_MEMA;
                    end
                endcase
                cnt_next = cnt_reg + 2'd1;
            end
            S_MEMA: begin
                if (cur_reg.op == OP_SW) begin
                    dm_we      = 1'b1;
                    res_next   = RESULT_NONE;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_LOADW;
                end
            end
            S_LOADW: begin
                res_next   = dm_rdata_reg;
                rf_we      = 1'b1;
                rf_wdata   = dm_rdata_reg;
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_MULW: begin
                res_next   = prod_reg[31:0];
                ovf_next   = !((&prod_reg[63:31]) || !(|prod_reg[63:31]));
                rf_we      = 1'b1;
                rf_wdata   = prod_reg[31:0];
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pc_reg      <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        mod_reg  <= mod_next;
        cnt_reg  <= cnt_next;
        if (emit) begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
            bad_reg <= bad_next;
            pco_reg <= pc_next;
        end
    end

    // Register file valid bits; an unwritten register reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
        end else begin
            if (rf_we) begin
                rf_valid_reg[cur_reg.dest[RW-1:0]] <= 1'b1;
            end
            if (q_pop) begin
                va_reg <= rf_valid_reg[q_item.src[RW-1:0]];
                vb_reg <= rf_valid_reg[q_item.bsel[RW-1:0]];
            end
        end
    end

    // Register file storage with two registered read ports.
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[cur_reg.dest[RW-1:0]] <= rf_wdata;
        end
        if (q_pop) begin
            ra_reg <= rf_mem[q_item.src[RW-1:0]];
            rb_reg <= rf_mem[q_item.bsel[RW-1:0]];
        end
    end

    // Data memory, one port.
    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[dm_addr] <= dm_wdata;
        end
        dm_rdata_reg <= dm_mem[dm_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, pco_reg, bad_reg, ovf_reg, res_reg};

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result produced while the result register is occupied");
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == S_EXEC))
        else $error("popped instruction did not reach execution");
    a_no_rf_write_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!rf_we && !emit))
        else $error("activity during the memory clearing pass");
    a_exec_after_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> ($past(state_reg) == S_IDLE))
        else $error("execution entered without a pop");
`endif

endmodule

// ===== sv/risc_execute_stage.sv =====
// A word is queued, popped in idle with a registered register-file read, executed
// and its result registered. Multiply-immediate adds a multiply-wait state, store
// a memory-access state, load that and a load-wait state; when MEM_WORDS is not a
// power of two, a reciprocal address reduction comes before the memory access.
// Words run one at a time, popped only in idle while the result register is free.
// Reset: a pass clears the data memory; s_tready stays low until it ends.
// ----------------------------------------------------------------------------
// risc_execute_stage: execute stage of a small 32-bit RISC
// Decoded instructions run against a register file, a pc and data memory.
// ----------------------------------------------------------------------------
module risc_execute_stage import ree_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op, dest_index, src_index, second_index, shift_amount, immediate,
    // jump_target from the lowest bit up
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result, overflow, bad_opcode, pc_value from the lowest bit up
    output logic [71:0] m_tdata
);

    logic  q_valid;
    logic  q_pop;
    logic  clear_done;
    item_t q_item;

    ree_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_done (clear_done),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    ree_back #(
        .REG_COUNT (REG_COUNT),
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== tb/tb_risc_execute_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_risc_execute_stage: self-checking bench for the RISC execute stage
// Drives decoded instruction words through the input stream, keeps its own
// copy of registers, pc and data memory to predict each result word, and
// compares every result word field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_risc_execute_stage;
    import ree_pkg::*;

    localparam int NREG  = REG_COUNT_DEF;
    localparam int NMEM  = MEM_WORDS_DEF;
    localparam int LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // op, dest_index, src_index, second_index, shift_amount, immediate,
    // jump_target from the lowest bit up
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // result, overflow, bad_opcode, pc_value from the lowest bit up
    logic [71:0] m_tdata;

    typedef struct packed {
        logic [31:0] pc;
        logic        bad;
        logic        ovf;
        logic [31:0] value;
    } outcome_t;

    // Predicted machine state.
    logic [31:0] gold_regs [NREG];
    logic [31:0] gold_mem [NMEM];
    logic [31:0] gold_pc;
    outcome_t    pending_outcomes [$];

    int  errors;
    int  cycles;
    bit  drain_phase;
    bit  hold_off_req;
    int  hold_off_len;

    risc_execute_stage DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Execute one instruction on the predicted state.
    function automatic outcome_t execute_instr(logic [3:0] op, logic [4:0] rd,
            logic [4:0] rs, logic [4:0] rt, logic [4:0] sh, logic [17:0] imm18,
            logic [27:0] tgt);
        outcome_t    o;
        logic [31:0] a, b, imm, r;
        logic [63:0] prod;
        logic [10:0] addr;
        a    = gold_regs[rs];
        b    = gold_regs[rt];
        imm  = {{14{imm18[17]}}, imm18};
        r    = 32'd0;
        o    = '0;
        addr = 11'(a + imm);
        case (op)
            OP_ADD: begin
                r = a + b;
                o.ovf = (a[31] == b[31]) && (r[31] != a[31]);
                gold_regs[rd] = r;
            end
            OP_SUB: begin
                r = a - b;
                o.ovf = (a[31] != b[31]) && (r[31] != a[31]);
                gold_regs[rd] = r;
            end
            OP_MULI: begin
                prod = $signed(a) * $signed(imm);
                r = prod[31:0];
                o.ovf = (prod[63:31] != {33{1'b0}}) && (prod[63:31] != {33{1'b1}});
                gold_regs[rd] = r;
            end
            OP_ADDI: begin
                r = a + imm;
                o.ovf = (a[31] == imm[31]) && (r[31] != a[31]);
                gold_regs[rd] = r;
            end
            OP_BNE: begin
                if (gold_regs[rd] != a) gold_pc = gold_pc + 32'd1 + imm;
                r = RESULT_NONE;
            end
            OP_ANDI: begin
                r = a & imm;
                gold_regs[rd] = r;
            end
            OP_ORI: begin
                r = a | imm;
                gold_regs[rd] = r;
            end
            OP_JMP: begin
                gold_pc = (gold_pc & PC_KEEP_MASK) | {4'd0, tgt};
                r = RESULT_NONE;
            end
            OP_SLL: begin
                r = a << sh;
                gold_regs[rd] = r;
            end
            OP_SRL: begin
                r = a >> sh;
                gold_regs[rd] = r;
            end
            OP_LW: begin
                r = gold_mem[addr];
                gold_regs[rd] = r;
            end
            OP_SW: begin
                gold_mem[addr] = gold_regs[rd];
                r = RESULT_NONE;
            end
            default: o.bad = 1'b1;
        endcase
        o.value = r;
        o.pc    = gold_pc;
        return o;
    endfunction

    // Send one instruction word, with a random gap before it outside the drain phase.
    task automatic send_instr(logic [3:0] op, logic [4:0] rd, logic [4:0] rs,
            logic [4:0] rt, logic [4:0] sh, logic [17:0] imm, logic [27:0] tgt);
        int gap;
        if (!drain_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {tgt, imm, sh, rt, rs, rd, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outcomes.push_back(execute_instr(op, rd, rs, rt, sh, imm, tgt));
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    // Random word with mostly small immediate values so loads and stores hit
    // written memory and operands stay in range of the overflow edges.
    task automatic send_random(int n);
        logic [3:0]  op;
        logic [17:0] imm;
        repeat (n) begin
            op  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11));
            imm = ($urandom_range(0, 2) == 0) ? 18'($urandom)
                                              : 18'($signed($urandom_range(0, 64)) - 32);
            send_instr(op, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                       imm, 28'($urandom));
        end
    endtask

    // Extremes: build large and negative register values, then overflow cases.
    task automatic test_arith_edges();
        send_instr(OP_ADDI, 5'd1, 5'd0, 5'd0, 5'd0, 18'h1FFFF, 28'd0);
        send_instr(OP_SLL, 5'd2, 5'd1, 5'd0, 5'd14, 18'd0, 28'd0);
        send_instr(OP_ORI, 5'd3, 5'd2, 5'd0, 5'd0, 18'h3FFFF, 28'd0);
        send_instr(OP_SRL, 5'd4, 5'd3, 5'd0, 5'd1, 18'd0, 28'd0);
        send_instr(OP_ADD, 5'd5, 5'd4, 5'd4, 5'd0, 18'd0, 28'd0);
        send_instr(OP_SUB, 5'd6, 5'd3, 5'd4, 5'd0, 18'd0, 28'd0);
        send_instr(OP_ADDI, 5'd7, 5'd4, 5'd0, 5'd0, 18'd1, 28'd0);
        send_instr(OP_MULI, 5'd8, 5'd4, 5'd0, 5'd0, 18'h20000, 28'd0);
        send_instr(OP_MULI, 5'd9, 5'd3, 5'd0, 5'd0, 18'h3FFFF, 28'd0);
        send_instr(OP_ANDI, 5'd31, 5'd3, 5'd0, 5'd31, 18'h2AAAA, 28'd0);
        send_instr(OP_SLL, 5'd10, 5'd3, 5'd0, 5'd31, 18'd0, 28'd0);
        wait_drained();
    endtask

    // Memory wrap, branches both ways, jump and unknown opcodes.
    task automatic test_control_and_memory();
        send_instr(OP_SW, 5'd3, 5'd0, 5'd0, 5'd0, 18'h3FFFF, 28'd0);
        send_instr(OP_LW, 5'd11, 5'd1, 5'd0, 5'd0, 18'h20000, 28'd0);
        send_instr(OP_LW, 5'd12, 5'd0, 5'd0, 5'd0, 18'h007FF, 28'd0);
        send_instr(OP_BNE, 5'd3, 5'd3, 5'd0, 5'd0, 18'h00005, 28'd0);
        send_instr(OP_BNE, 5'd3, 5'd0, 5'd0, 5'd0, 18'h20000, 28'd0);
        send_instr(OP_JMP, 5'd0, 5'd0, 5'd0, 5'd0, 18'd0, 28'hFFFFFFF);
        send_instr(OP_BNE, 5'd1, 5'd0, 5'd0, 5'd0, 18'h1FFFF, 28'd0);
        send_instr(4'd12, 5'd31, 5'd31, 5'd31, 5'd31, 18'h3FFFF, 28'hFFFFFFF);
        send_instr(4'd15, 5'd0, 5'd0, 5'd0, 5'd0, 18'd0, 28'd0);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        hold_off_len = 300;
        hold_off_req = 1'b1;
        send_random(30);
        hold_off_req = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        send_random(1500);
        drain_phase = 1'b1;
        send_random(150);
        wait_drained();
    endtask

    // Result side: random stalls, a long hold-off on request, and checking.
    initial begin : result_sink
        int stall;
        outcome_t want, got;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (hold_off_len) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (!drain_phase && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = outcome_t'({m_tdata[65:34], m_tdata[33], m_tdata[32], m_tdata[31:0]});
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: result expected %h actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.ovf, got.ovf);
                        errors++;
                    end
                    if (got.bad !== want.bad) begin
                        $display("%0t: bad_opcode expected %b actual %b",
                                 $time, want.bad, got.bad);
                        errors++;
                    end
                    if (got.pc !== want.pc) begin
                        $display("%0t: pc_value expected %h actual %h",
                                 $time, want.pc, got.pc);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        errors       = 0;
        cycles       = 0;
        drain_phase  = 1'b0;
        hold_off_req = 1'b0;
        hold_off_len = 0;
        gold_pc      = '0;
        foreach (gold_regs[i]) gold_regs[i] = '0;
        foreach (gold_mem[i]) gold_mem[i] = '0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_arith_edges();
        test_control_and_memory();
        test_backpressure();
        test_random_traffic();

        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ree_pkg.sv
sv/ree_front.sv
sv/ree_back.sv
sv/risc_execute_stage.sv
tb/tb_risc_execute_stage.sv
